### hw/rtl/csrq_pkg.sv
// ----------------------------------------------------------------------------
// csrq_pkg
// Shared types and codes for the coalescing sound request queue.
// ----------------------------------------------------------------------------
package csrq_pkg;

  localparam int unsigned QUEUE_DEPTH_DEF = 16;

  localparam int unsigned SLOT_W  = 16;
  localparam int unsigned GEN_W   = 16;
  localparam int unsigned REQV_W  = 10;
  localparam int unsigned VOL_W   = 9;
  localparam int unsigned PITCH_W = 16;
  localparam int unsigned DROP_W  = 16;
  localparam int unsigned KIND_W  = 2;

  localparam int unsigned IN_DATA_W  = 64;
  localparam int unsigned OUT_DATA_W = 80;

  localparam logic [VOL_W-1:0]   UNITY_VOL   = 9'd256;
  localparam logic [PITCH_W-1:0] UNITY_PITCH = 16'd256;
  localparam logic [DROP_W-1:0]  DROP_MAX    = 16'hFFFF;

  // command codes (tuser on the input side)
  localparam logic CMD_ENQ   = 1'b0;
  localparam logic CMD_FLUSH = 1'b1;

  // result kinds (tuser on the output side)
  localparam logic [KIND_W-1:0] KIND_ACCEPT = 2'd0;
  localparam logic [KIND_W-1:0] KIND_REJECT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_PLAY   = 2'd2;
  localparam logic [KIND_W-1:0] KIND_DONE   = 2'd3;

  // configuration register indexes
  localparam logic REG_GAIN = 1'b0;
  localparam logic REG_MUTE = 1'b1;

  typedef struct packed {
    logic [SLOT_W-1:0]  slot;
    logic [GEN_W-1:0]   gen;
    logic [VOL_W-1:0]   vol;
    logic [PITCH_W-1:0] pitch;
  } entry_t;

  typedef struct packed {
    logic [VOL_W-1:0] gain;   // already limited to unity
    logic             mute;
  } cfg_t;

endpackage

### hw/rtl/csrq_store.sv
// ----------------------------------------------------------------------------
// csrq_store
// Entry memory: one write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module csrq_store #(
  parameter int unsigned QUEUE_DEPTH = csrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [IDX_W-1:0]    waddr_i,
  input  csrq_pkg::entry_t    wdata_i,
  input  logic                re_i,
  input  logic [IDX_W-1:0]    raddr_i,
  output csrq_pkg::entry_t    rdata_o
);

  csrq_pkg::entry_t mem [QUEUE_DEPTH];
  csrq_pkg::entry_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/csrq_seq.sv
// ----------------------------------------------------------------------------
// csrq_seq
// Sequencer: scans the entry store for a duplicate handle on enqueue,
// streams the entries through the gain multiplier on flush, and holds the
// output register.
// ----------------------------------------------------------------------------
module csrq_seq #(
  parameter int unsigned QUEUE_DEPTH = csrq_pkg::QUEUE_DEPTH_DEF,
  parameter int unsigned IDX_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  parameter int unsigned CNT_W       = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  csrq_pkg::cfg_t                      cfg_i,
  // input beats
  input  logic                                s_tvalid_i,
  output logic                                s_tready_o,
  input  logic [csrq_pkg::IN_DATA_W-1:0]      s_tdata_i,
  input  logic                                s_tuser_i,
  // result beats
  output logic                                m_tvalid_o,
  input  logic                                m_tready_i,
  output logic [csrq_pkg::OUT_DATA_W-1:0]     m_tdata_o,
  output logic [csrq_pkg::KIND_W-1:0]         m_tuser_o,
  output logic                                m_tlast_o,
  // entry store
  output logic                                we_o,
  output logic [IDX_W-1:0]                    waddr_o,
  output csrq_pkg::entry_t                    wdata_o,
  output logic                                re_o,
  output logic [IDX_W-1:0]                    raddr_o,
  input  csrq_pkg::entry_t                    rdata_i
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_FLUSH = 2'd2;
  localparam logic [1:0] ST_EMIT  = 2'd3;

  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);
  localparam int unsigned      PROD_W   = 2 * csrq_pkg::VOL_W;

  logic [1:0]                      state_q, state_d;
  logic [CNT_W-1:0]                idx_q, idx_d;
  logic [CNT_W-1:0]                count_q, count_d;
  logic                            pend_q, pend_d;
  logic [IDX_W-1:0]                pend_idx_q, pend_idx_d;
  logic [csrq_pkg::DROP_W-1:0]     drop_q, drop_d;
  csrq_pkg::entry_t                req_q, req_d;
  logic [csrq_pkg::KIND_W-1:0]     res_kind_q, res_kind_d;

  logic                            out_vld_q, out_vld_d;
  logic [csrq_pkg::KIND_W-1:0]     out_kind_q, out_kind_d;
  csrq_pkg::entry_t                out_ent_q, out_ent_d;
  logic                            out_last_q, out_last_d;
  logic [csrq_pkg::DROP_W-1:0]     out_drop_q, out_drop_d;

  // input fields
  logic [csrq_pkg::SLOT_W-1:0]     in_slot;
  logic [csrq_pkg::GEN_W-1:0]      in_gen;
  logic [csrq_pkg::REQV_W-1:0]     in_vol;
  logic [csrq_pkg::PITCH_W-1:0]    in_pitch;

  logic                            can_load;
  logic                            more;
  logic                            hit;
  logic                            play_en;
  logic [PROD_W-1:0]               prod;
  csrq_pkg::entry_t                merged;

  assign in_slot  = s_tdata_i[15:0];
  assign in_gen   = s_tdata_i[31:16];
  assign in_vol   = s_tdata_i[41:32];
  assign in_pitch = s_tdata_i[57:42];

  assign can_load = !out_vld_q || m_tready_i;
  assign more     = idx_q < count_q;
  assign hit      = pend_q && (rdata_i.slot == req_q.slot) && (rdata_i.gen == req_q.gen);
  assign play_en  = !cfg_i.mute && (cfg_i.gain != '0);
  assign prod     = PROD_W'(rdata_i.vol) * PROD_W'(cfg_i.gain);

  always_comb begin
    merged = rdata_i;
    if (req_q.vol > rdata_i.vol) begin
      merged.vol = req_q.vol;
    end
  end

  always_comb begin
    state_d    = state_q;
    idx_d      = idx_q;
    count_d    = count_q;
    pend_d     = pend_q;
    pend_idx_d = pend_idx_q;
    drop_d     = drop_q;
    req_d      = req_q;
    res_kind_d = res_kind_q;

    out_vld_d  = out_vld_q && !m_tready_i;
    out_kind_d = out_kind_q;
    out_ent_d  = out_ent_q;
    out_last_d = out_last_q;
    out_drop_d = out_drop_q;

    s_tready_o = 1'b0;
    we_o       = 1'b0;
    waddr_o    = count_q[IDX_W-1:0];
    wdata_o    = req_q;
    re_o       = 1'b0;
    raddr_o    = idx_q[IDX_W-1:0];

    case (state_q)
      ST_IDLE: begin
        s_tready_o = 1'b1;
        if (s_tvalid_i) begin
          req_d.slot  = in_slot;
          req_d.gen   = in_gen;
          req_d.vol   = (in_vol > csrq_pkg::REQV_W'(csrq_pkg::UNITY_VOL)) ?
                        csrq_pkg::UNITY_VOL : in_vol[csrq_pkg::VOL_W-1:0];
          req_d.pitch = (in_pitch == '0) ? csrq_pkg::UNITY_PITCH : in_pitch;
          idx_d       = '0;
          pend_d      = 1'b0;
          if (s_tuser_i == csrq_pkg::CMD_FLUSH) begin
            state_d = ST_FLUSH;
          end else if (in_gen == '0) begin
            res_kind_d = csrq_pkg::KIND_REJECT;
            state_d    = ST_EMIT;
          end else begin
            state_d = ST_SCAN;
          end
        end
      end

      ST_SCAN: begin
        if (hit) begin
          we_o       = 1'b1;
          waddr_o    = pend_idx_q;
          wdata_o    = merged;
          pend_d     = 1'b0;
          res_kind_d = csrq_pkg::KIND_ACCEPT;
          state_d    = ST_EMIT;
        end else if (more) begin
          // read the next entry while the previous one is compared
          re_o       = 1'b1;
          pend_d     = 1'b1;
          pend_idx_d = idx_q[IDX_W-1:0];
          idx_d      = idx_q + 1'b1;
        end else begin
          pend_d  = 1'b0;
          state_d = ST_EMIT;
          if (count_q == FULL_CNT) begin
            res_kind_d = csrq_pkg::KIND_REJECT;
            if (drop_q != csrq_pkg::DROP_MAX) begin
              drop_d = drop_q + 1'b1;
            end
          end else begin
            we_o       = 1'b1;
            count_d    = count_q + 1'b1;
            res_kind_d = csrq_pkg::KIND_ACCEPT;
          end
        end
      end

      ST_FLUSH: begin
        if (!play_en || (!pend_q && !more)) begin
          if (can_load) begin
            out_vld_d  = 1'b1;
            out_kind_d = csrq_pkg::KIND_DONE;
            out_ent_d  = '0;
            out_last_d = 1'b1;
            out_drop_d = drop_q;
            count_d    = '0;
            pend_d     = 1'b0;
            state_d    = ST_IDLE;
          end
        end else if (!pend_q || can_load) begin
          if (pend_q) begin
            out_vld_d       = 1'b1;
            out_kind_d      = csrq_pkg::KIND_PLAY;
            out_ent_d       = rdata_i;
            out_ent_d.vol   = prod[csrq_pkg::VOL_W+7:8];
            out_last_d      = 1'b0;
            out_drop_d      = drop_q;
          end
          pend_d = 1'b0;
          if (more) begin
            re_o   = 1'b1;
            pend_d = 1'b1;
            idx_d  = idx_q + 1'b1;
          end
        end
      end

      ST_EMIT: begin
        if (can_load) begin
          out_vld_d  = 1'b1;
          out_kind_d = res_kind_q;
          out_ent_d  = '0;
          out_last_d = 1'b1;
          out_drop_d = drop_q;
          state_d    = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      idx_q     <= '0;
      count_q   <= '0;
      pend_q    <= 1'b0;
      drop_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      idx_q     <= idx_d;
      count_q   <= count_d;
      pend_q    <= pend_d;
      drop_q    <= drop_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_idx_q <= pend_idx_d;
    req_q      <= req_d;
    res_kind_q <= res_kind_d;
    out_kind_q <= out_kind_d;
    out_ent_q  <= out_ent_d;
    out_last_q <= out_last_d;
    out_drop_q <= out_drop_d;
  end

  assign m_tvalid_o = out_vld_q;
  assign m_tuser_o  = out_kind_q;
  assign m_tlast_o  = out_last_q;
  assign m_tdata_o  = {7'd0, out_drop_q, out_ent_q.pitch, out_ent_q.vol,
                       out_ent_q.gen, out_ent_q.slot};

endmodule

### hw/rtl/coalescing_sound_request_queue.sv
// ----------------------------------------------------------------------------
// coalescing_sound_request_queue
// Bounded queue of play requests that merges duplicate handles.
// ----------------------------------------------------------------------------
// Input beats carry an enqueue (tuser 0) or a flush (tuser 1). Every enqueue
// gives one result beat: accepted, or rejected for a zero generation or a
// full queue (the drop counter saturates at 65535). A flush gives one play
// beat per queued entry, in queue order, with volume scaled by master gain,
// then a done beat with tlast high; muted or zero gain gives the done beat
// alone. The queue is emptied either way.
// Timing: the entry store is read one entry a cycle through its single
// registered read port, unless a stalled receiver holds a flush. tready is
// low until the item is finished, so no new input beat is taken while an
// enqueue or a flush is under way.
// Results sit in an output register; a stalled receiver holds the sequencer
// but a finished result never blocks the next input beat. Reset empties the
// queue, clears the drop counter, sets gain to unity and unmutes. The APB
// port writes gain at 0x0 and mute at 0x4; the user must write them only
// while idle, as the block itself does not enforce this.
// ----------------------------------------------------------------------------
module coalescing_sound_request_queue #(
  parameter int unsigned QUEUE_DEPTH = csrq_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // configuration
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [2:0]                       paddr,
  input  logic [31:0]                      pwdata,
  output logic [31:0]                      prdata,
  output logic                             pready,
  // input: slot[15:0], gen[31:16], req_volume[41:32], req_pitch[57:42]
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [csrq_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  // tuser: cmd[0]
  input  logic                             s_axis_tuser,
  // output: out_slot[15:0], out_gen[31:16], play_volume[40:32],
  //         play_pitch[56:41], drop_total[72:57]
  output logic                             m_axis_tvalid,
  input  logic                             m_axis_tready,
  output logic [csrq_pkg::OUT_DATA_W-1:0]  m_axis_tdata,
  // tuser: kind[1:0]
  output logic [csrq_pkg::KIND_W-1:0]      m_axis_tuser,
  output logic                             m_axis_tlast
);

  localparam int unsigned IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [csrq_pkg::VOL_W-1:0] gain_q;
  logic                       mute_q;
  logic                       reg_sel;
  logic                       wr_en;
  csrq_pkg::cfg_t             cfg;

  logic                       we;
  logic [IDX_W-1:0]           waddr;
  csrq_pkg::entry_t           wdata;
  logic                       re;
  logic [IDX_W-1:0]           raddr;
  csrq_pkg::entry_t           rdata;

  assign pready  = 1'b1;
  assign reg_sel = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_q <= csrq_pkg::UNITY_VOL;
      mute_q <= 1'b0;
    end else if (wr_en) begin
      if (reg_sel == csrq_pkg::REG_GAIN) begin
        gain_q <= pwdata[csrq_pkg::VOL_W-1:0];
      end else begin
        mute_q <= pwdata[0];
      end
    end
  end

  always_comb begin
    if (reg_sel == csrq_pkg::REG_GAIN) begin
      prdata = {23'd0, gain_q};
    end else begin
      prdata = {31'd0, mute_q};
    end
  end

  // gain above unity acts as unity
  assign cfg.gain = (gain_q > csrq_pkg::UNITY_VOL) ? csrq_pkg::UNITY_VOL : gain_q;
  assign cfg.mute = mute_q;

  csrq_seq #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W),
    .CNT_W       (CNT_W)
  ) u_seq (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg),
    .s_tvalid_i (s_axis_tvalid),
    .s_tready_o (s_axis_tready),
    .s_tdata_i  (s_axis_tdata),
    .s_tuser_i  (s_axis_tuser),
    .m_tvalid_o (m_axis_tvalid),
    .m_tready_i (m_axis_tready),
    .m_tdata_o  (m_axis_tdata),
    .m_tuser_o  (m_axis_tuser),
    .m_tlast_o  (m_axis_tlast),
    .we_o       (we),
    .waddr_o    (waddr),
    .wdata_o    (wdata),
    .re_o       (re),
    .raddr_o    (raddr),
    .rdata_i    (rdata)
  );

  csrq_store #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .IDX_W       (IDX_W)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .re_i    (re),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

endmodule
